[rtl/core/nmea_sentence_framer_macros.svh]
// Assertion helpers shared by the framer's modules.
`ifndef NMEA_SENTENCE_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define NSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Implication form: cons must hold whenever ante holds.
`define NSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/core/nsf_pkg.sv]
package nsf_pkg;

  localparam int MaxSentence = 128;
  localparam int CntW        = $clog2(MaxSentence);
  localparam int QDepth      = 4;
  localparam int QIdxW       = $clog2(QDepth);

  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChEnd   = 8'h0A;
  localparam logic [7:0] ChStar  = 8'h2A;

  typedef enum logic [0:0] {
    KindBody    = 1'b0,
    KindVerdict = 1'b1
  } nsf_kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFraming  = 3'd1,
    StMismatch = 3'd2,
    StOverflow = 3'd3,
    StShort    = 3'd4
  } nsf_status_e;

  typedef enum logic [1:0] {
    TypeOther = 2'd0,
    TypeGga   = 2'd1,
    TypeRmc   = 2'd2
  } nsf_type_e;

  // One classified beat as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
    logic       is_star;
    logic       hex_ok;
    logic [3:0] hex_val;
  } nsf_entry_t;

  function automatic logic [7:0] gga_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "G";
      3'd1:    c = "P";
      3'd2:    c = "G";
      3'd3:    c = "G";
      3'd4:    c = "A";
      3'd5:    c = ",";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rmc_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "G";
      3'd1:    c = "P";
      3'd2:    c = "R";
      3'd3:    c = "M";
      3'd4:    c = "C";
      3'd5:    c = ",";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/nmea_sentence_framer.sv]
// NMEA 0183 sentence framer. Received characters come in one beat at a time;
// everything is dropped until '$', then each character except line feed is
// held in a four-deep tail window and the character leaving the window goes
// out as a body beat (with its index) and into the XOR checksum. Line feed
// yields one verdict beat: status (ok, framing error, checksum mismatch,
// overflow, body under six), GPGGA/GPRMC/other type, body length and the
// computed checksum. A character that would bring the count after '$' to 127
// is dropped and the sentence is cut off with an overflow verdict. A classifier
// writes a four-entry queue and the sequencer behind it drains one entry per
// cycle into the output register, so one beat per clock is sustained while the
// output is not stalled.
module nmea_sentence_framer import nsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  body_byte_o,
  output logic [6:0]  body_index_o,
  output logic [2:0]  status_o,
  output logic [1:0]  sentence_type_o,
  output logic [6:0]  body_length_o,
  output logic [7:0]  checksum_o
);

  logic        q_full, q_push, q_empty, q_pop;
  nsf_entry_t  q_wr, q_rd;
  nsf_kind_e   kind;
  nsf_status_e status;
  nsf_type_e   stype;

  nsf_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr)
  );

  nsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_rd)
  );

  nsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_entry_i       (q_rd),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (kind),
    .body_byte_o     (body_byte_o),
    .body_index_o    (body_index_o),
    .status_o        (status),
    .sentence_type_o (stype),
    .body_length_o   (body_length_o),
    .checksum_o      (checksum_o)
  );

  assign result_kind_o   = kind;
  assign status_o        = status;
  assign sentence_type_o = stype;

endmodule

[rtl/core/nsf_front.sv]
module nsf_front import nsf_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output nsf_entry_t q_entry_o
);

  logic       is_digit, is_upper, is_lower;
  logic [7:0] off_digit, off_upper, off_lower;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign off_digit = rx_byte_i - 8'h30;
  assign off_upper = rx_byte_i - 8'h37;
  assign off_lower = rx_byte_i - 8'h57;

  assign is_digit = (rx_byte_i >= 8'h30) && (rx_byte_i <= 8'h39);
  assign is_upper = (rx_byte_i >= 8'h41) && (rx_byte_i <= 8'h46);
  assign is_lower = (rx_byte_i >= 8'h61) && (rx_byte_i <= 8'h66);

  always_comb begin
    q_entry_o.data     = rx_byte_i;
    q_entry_o.is_start = (rx_byte_i == ChStart);
    q_entry_o.is_end   = (rx_byte_i == ChEnd);
    q_entry_o.is_star  = (rx_byte_i == ChStar);
    q_entry_o.hex_ok   = is_digit || is_upper || is_lower;
    if (is_digit) begin
      q_entry_o.hex_val = off_digit[3:0];
    end else if (is_upper) begin
      q_entry_o.hex_val = off_upper[3:0];
    end else begin
      q_entry_o.hex_val = off_lower[3:0];
    end
  end

endmodule

[rtl/core/nsf_queue.sv]
`include "nmea_sentence_framer_macros.svh"

module nsf_queue import nsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nsf_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output nsf_entry_t entry_o
);

  nsf_entry_t           mem_q [QDepth];
  logic [QIdxW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [QIdxW:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QIdxW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QIdxW+1)'(push_i) - (QIdxW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `NSF_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= (QIdxW+1)'(QDepth))
  `NSF_ASSERT_IMP(a_no_over, clk_i, rst_ni, full_o, !push_i)
  `NSF_ASSERT_IMP(a_no_under, clk_i, rst_ni, empty_o, !pop_i)
  `NSF_ASSERT(a_ptr_gap, clk_i, rst_ni,
              (cnt_q == (QIdxW+1)'(QDepth)) || (cnt_q == '0) ? wr_q == rd_q : wr_q != rd_q)

endmodule

[rtl/core/nsf_back.sv]
`include "nmea_sentence_framer_macros.svh"

module nsf_back import nsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  nsf_entry_t  q_entry_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output nsf_kind_e   result_kind_o,
  output logic [7:0]  body_byte_o,
  output logic [6:0]  body_index_o,
  output nsf_status_e status_o,
  output nsf_type_e   sentence_type_o,
  output logic [6:0]  body_length_o,
  output logic [7:0]  checksum_o
);

  logic            in_sent_q, in_sent_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      xor_q, xor_d;
  logic            star_q, star_d;
  logic            gga_q, gga_d;
  logic            rmc_q, rmc_d;
  nsf_entry_t      win_q [4];
  logic            shift;

  logic            out_valid_q, out_valid_d;
  nsf_kind_e       kind_q, kind_d;
  logic [7:0]      byte_q, byte_d;
  logic [6:0]      idx_q, idx_d;
  nsf_status_e     status_q, status_d;
  nsf_type_e       type_q, type_d;
  logic [6:0]      len_q, len_d;
  logic [7:0]      xsum_q, xsum_d;

  logic            can_take, res_valid, full;
  logic [CntW-1:0] body_sent;
  nsf_type_e       cur_type;
  nsf_entry_t      old;

  assign can_take = !out_valid_q || !out_stall_i;
  assign q_pop_o  = !q_empty_i && can_take;
  assign full     = (cnt_q >= CntW'(4));
  assign body_sent = full ? cnt_q - CntW'(4) : '0;
  assign old      = win_q[0];

  always_comb begin
    if (body_sent < CntW'(6)) begin
      cur_type = TypeOther;
    end else if (gga_q) begin
      cur_type = TypeGga;
    end else if (rmc_q) begin
      cur_type = TypeRmc;
    end else begin
      cur_type = TypeOther;
    end
  end

  always_comb begin
    in_sent_d = in_sent_q;
    cnt_d     = cnt_q;
    xor_d     = xor_q;
    star_d    = star_q;
    gga_d     = gga_q;
    rmc_d     = rmc_q;
    shift     = 1'b0;
    res_valid = 1'b0;
    kind_d    = KindBody;
    byte_d    = '0;
    idx_d     = '0;
    status_d  = StOk;
    type_d    = TypeOther;
    len_d     = '0;
    xsum_d    = '0;

    if (q_pop_o) begin
      if (!in_sent_q) begin
        if (q_entry_i.is_start) begin
          in_sent_d = 1'b1;
        end
      end else if (q_entry_i.is_end || cnt_q >= CntW'(MaxSentence - 2)) begin
        res_valid = 1'b1;
        kind_d    = KindVerdict;
        if (!q_entry_i.is_end) begin
          status_d = StOverflow;
          type_d   = cur_type;
          len_d    = 7'(body_sent);
          xsum_d   = xor_q;
        end else if (full) begin
          type_d = cur_type;
          len_d  = 7'(body_sent);
          xsum_d = xor_q;
          if (!win_q[0].is_star || star_q || !win_q[1].hex_ok || !win_q[2].hex_ok) begin
            status_d = StFraming;
          end else if ({win_q[1].hex_val, win_q[2].hex_val} != xor_q) begin
            status_d = StMismatch;
          end else if (body_sent < CntW'(6)) begin
            status_d = StShort;
          end
        end else begin
          status_d = StFraming;
        end
        in_sent_d = 1'b0;
        cnt_d     = '0;
        xor_d     = '0;
        star_d    = 1'b0;
        gga_d     = 1'b1;
        rmc_d     = 1'b1;
      end else begin
        shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (full) begin
          res_valid = 1'b1;
          byte_d    = old.data;
          idx_d     = 7'(body_sent);
          xor_d     = xor_q ^ old.data;
          if (old.is_star) begin
            star_d = 1'b1;
          end
          // prefix match only looks at the first six body beats
          if (body_sent < CntW'(6)) begin
            if (old.data != gga_char(body_sent[2:0])) begin
              gga_d = 1'b0;
            end
            if (old.data != rmc_char(body_sent[2:0])) begin
              rmc_d = 1'b0;
            end
          end
        end
      end
    end

    out_valid_d = can_take ? res_valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q   <= 1'b0;
      cnt_q       <= '0;
      xor_q       <= '0;
      star_q      <= 1'b0;
      gga_q       <= 1'b1;
      rmc_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      in_sent_q   <= in_sent_d;
      cnt_q       <= cnt_d;
      xor_q       <= xor_d;
      star_q      <= star_d;
      gga_q       <= gga_d;
      rmc_q       <= rmc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // tail window contents only matter once four beats have gone in
  always_ff @(posedge clk_i) begin
    if (shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= q_entry_i;
    end
    if (res_valid && can_take) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      type_q   <= type_d;
      len_q    <= len_d;
      xsum_q   <= xsum_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign body_byte_o     = byte_q;
  assign body_index_o    = idx_q;
  assign status_o        = status_q;
  assign sentence_type_o = type_q;
  assign body_length_o   = len_q;
  assign checksum_o      = xsum_q;

  `NSF_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= CntW'(MaxSentence - 2))
  `NSF_ASSERT_IMP(a_hunt_idle, clk_i, rst_ni, !in_sent_q,
                  cnt_q == '0 && xor_q == '0 && !star_q && gga_q && rmc_q)
  `NSF_ASSERT_IMP(a_verdict_hunts, clk_i, rst_ni,
                  out_valid_q && kind_q == KindVerdict, !in_sent_q)
  `NSF_ASSERT_IMP(a_body_in_sent, clk_i, rst_ni,
                  out_valid_q && kind_q == KindBody, in_sent_q && cnt_q >= CntW'(5))

endmodule
